@@ rtl/c2p_pkg.sv @@
`default_nettype none

package c2p_pkg;

  localparam int C2P_COORD_WIDTH  = 16;
  localparam int C2P_CORDIC_STEPS = 16;
  localparam int C2P_TABLE_LEN    = 32;

  // Angle accumulator: degrees with 16 fraction bits, room for about +-512 degrees
  localparam int ZW        = 26;
  localparam int ANG_FRAC  = 16;
  localparam int OUT_FRAC  = 7;
  localparam int ANG_W     = 16;
  localparam int RADIUS_W  = 16;
  localparam int LOC_W     = 4;
  localparam int OUT_TDATA_W = ((RADIUS_W + ANG_W + LOC_W + 7) / 8) * 8;

  typedef logic signed [ZW-1:0] zval_t;

  typedef enum logic [LOC_W-1:0] {
    LOC_ORIGIN = 4'd0,
    LOC_POS_X  = 4'd1,
    LOC_POS_Y  = 4'd2,
    LOC_NEG_X  = 4'd3,
    LOC_NEG_Y  = 4'd4,
    LOC_QUAD1  = 4'd5,
    LOC_QUAD2  = 4'd6,
    LOC_QUAD3  = 4'd7,
    LOC_QUAD4  = 4'd8
  } loc_t;

  localparam zval_t Z_DEG90_FULL = 26'sd5898240;

  // Output-scale angles, 7 fraction bits
  localparam zval_t DEG0   = 26'sd0;
  localparam zval_t DEG90  = 26'sd11520;
  localparam zval_t DEG180 = 26'sd23040;

  // round(atan(2^-i) * 180/pi * 2^16)
  localparam zval_t ATAN_TAB [0:C2P_TABLE_LEN-1] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0,
    26'sd0,       26'sd0,       26'sd0,      26'sd0
  };

  function automatic zval_t clamp_ang(input zval_t v, input zval_t lo, input zval_t hi);
    zval_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/c2p_front.sv @@
`default_nettype none

module c2p_front #(
  parameter int COORD_WIDTH = 16,
  parameter int XW          = 35
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic signed [COORD_WIDTH-1:0] x_coord,
  input  wire logic signed [COORD_WIDTH-1:0] y_coord,
  output logic                               out_valid,
  output c2p_pkg::loc_t                      out_loc,
  output logic [2*COORD_WIDTH-1:0]           out_n,
  output logic signed [XW-1:0]               out_cx,
  output logic signed [XW-1:0]               out_cy,
  output c2p_pkg::zval_t                     out_z
);
  import c2p_pkg::*;

  localparam int W  = COORD_WIDTH;
  localparam int PW = W + 1;

  logic                   xneg, yneg, xzero, yzero;
  logic [W-1:0]           ax, ay;
  logic signed [PW-1:0]   xe, ye, px, py;
  zval_t                  za_nxt;
  loc_t                   loca_nxt;

  // stage A: magnitudes, squares, class, quarter-turn
  logic                   va_r;
  loc_t                   loca_r;
  logic [2*W-1:0]         sqx_r, sqy_r;
  logic signed [XW-1:0]   cxa_r, cya_r;
  zval_t                  za_r;

  // stage B: sum of squares
  logic                   vb_r;
  loc_t                   locb_r;
  logic [2*W-1:0]         nb_r;
  logic signed [XW-1:0]   cxb_r, cyb_r;
  zval_t                  zb_r;

  always_comb begin
    xneg  = x_coord[W-1];
    yneg  = y_coord[W-1];
    xzero = (x_coord == '0);
    yzero = (y_coord == '0);
    ax    = xneg ? W'(-x_coord) : W'(x_coord);
    ay    = yneg ? W'(-y_coord) : W'(y_coord);
    xe    = PW'(x_coord);
    ye    = PW'(y_coord);

    // bring the point into the right half-plane
    if (xneg && !yneg && !yzero) begin
      px     = ye;
      py     = -xe;
      za_nxt = Z_DEG90_FULL;
    end else if (xneg) begin
      px     = -ye;
      py     = xe;
      za_nxt = -Z_DEG90_FULL;
    end else begin
      px     = xe;
      py     = ye;
      za_nxt = '0;
    end

    if (xzero && yzero) begin
      loca_nxt = LOC_ORIGIN;
    end else if (yzero) begin
      loca_nxt = xneg ? LOC_NEG_X : LOC_POS_X;
    end else if (xzero) begin
      loca_nxt = yneg ? LOC_NEG_Y : LOC_POS_Y;
    end else if (!xneg && !yneg) begin
      loca_nxt = LOC_QUAD1;
    end else if (xneg && !yneg) begin
      loca_nxt = LOC_QUAD2;
    end else if (xneg) begin
      loca_nxt = LOC_QUAD3;
    end else begin
      loca_nxt = LOC_QUAD4;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loca_r <= loca_nxt;
      sqx_r  <= (2*W)'(ax) * (2*W)'(ax);
      sqy_r  <= (2*W)'(ay) * (2*W)'(ay);
      cxa_r  <= {{(XW-PW-16){px[PW-1]}}, px, 16'b0};
      cya_r  <= {{(XW-PW-16){py[PW-1]}}, py, 16'b0};
      za_r   <= za_nxt;

      locb_r <= loca_r;
      nb_r   <= sqx_r + sqy_r;
      cxb_r  <= cxa_r;
      cyb_r  <= cya_r;
      zb_r   <= za_r;
    end
  end

  assign out_valid = vb_r;
  assign out_loc   = locb_r;
  assign out_n     = nb_r;
  assign out_cx    = cxb_r;
  assign out_cy    = cyb_r;
  assign out_z     = zb_r;

endmodule

`default_nettype wire

@@ rtl/c2p_stage.sv @@
`default_nettype none

module c2p_stage #(
  parameter int COORD_WIDTH  = 16,
  parameter int XW           = 35,
  parameter int NSTEPS       = 16,
  parameter int IDX          = 0
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire c2p_pkg::loc_t               in_loc,
  input  wire logic [2*COORD_WIDTH-1:0]    in_rem,
  input  wire logic [2*COORD_WIDTH-1:0]    in_root,
  input  wire logic signed [XW-1:0]        in_cx,
  input  wire logic signed [XW-1:0]        in_cy,
  input  wire c2p_pkg::zval_t              in_z,
  output logic                             out_valid,
  output c2p_pkg::loc_t                    out_loc,
  output logic [2*COORD_WIDTH-1:0]         out_rem,
  output logic [2*COORD_WIDTH-1:0]         out_root,
  output logic signed [XW-1:0]             out_cx,
  output logic signed [XW-1:0]             out_cy,
  output c2p_pkg::zval_t                   out_z
);
  import c2p_pkg::*;

  localparam int NW = 2 * COORD_WIDTH;

  logic [NW-1:0]          rem_nxt, root_nxt;
  logic signed [XW-1:0]   cx_nxt, cy_nxt;
  zval_t                  z_nxt;

  logic                   v_r;
  loc_t                   loc_r;
  logic [NW-1:0]          rem_r, root_r;
  logic signed [XW-1:0]   cx_r, cy_r;
  zval_t                  z_r;

  // one micro-rotation, driven towards y = 0
  if (IDX < NSTEPS) begin : g_rot
    always_comb begin
      if (!in_cy[XW-1]) begin
        cx_nxt = in_cx + (in_cy >>> IDX);
        cy_nxt = in_cy - (in_cx >>> IDX);
        z_nxt  = in_z + ATAN_TAB[IDX];
      end else begin
        cx_nxt = in_cx - (in_cy >>> IDX);
        cy_nxt = in_cy + (in_cx >>> IDX);
        z_nxt  = in_z - ATAN_TAB[IDX];
      end
    end
  end else begin : g_rot_pass
    assign cx_nxt = in_cx;
    assign cy_nxt = in_cy;
    assign z_nxt  = in_z;
  end

  // one result bit of the square root
  if (IDX < COORD_WIDTH) begin : g_root
    localparam int SH = 2 * (COORD_WIDTH - 1 - IDX);
    logic [NW-1:0] sbit, trial;
    always_comb begin
      sbit  = {{(NW-1){1'b0}}, 1'b1} << SH;
      trial = in_root + sbit;
      if (in_rem >= trial) begin
        rem_nxt  = in_rem - trial;
        root_nxt = (in_root >> 1) + sbit;
      end else begin
        rem_nxt  = in_rem;
        root_nxt = in_root >> 1;
      end
    end
  end else begin : g_root_pass
    assign rem_nxt  = in_rem;
    assign root_nxt = in_root;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      loc_r  <= in_loc;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      cx_r   <= cx_nxt;
      cy_r   <= cy_nxt;
      z_r    <= z_nxt;
    end
  end

  assign out_valid = v_r;
  assign out_loc   = loc_r;
  assign out_rem   = rem_r;
  assign out_root  = root_r;
  assign out_cx    = cx_r;
  assign out_cy    = cy_r;
  assign out_z     = z_r;

endmodule

`default_nettype wire

@@ rtl/c2p_back.sv @@
`default_nettype none

module c2p_back #(
  parameter int COORD_WIDTH = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire c2p_pkg::loc_t               in_loc,
  input  wire logic [2*COORD_WIDTH-1:0]    in_rem,
  input  wire logic [2*COORD_WIDTH-1:0]    in_root,
  input  wire c2p_pkg::zval_t              in_z,
  output logic                             out_valid,
  output logic [c2p_pkg::RADIUS_W-1:0]     out_radius,
  output logic signed [c2p_pkg::ANG_W-1:0] out_angle,
  output c2p_pkg::loc_t                    out_loc
);
  import c2p_pkg::*;

  localparam int NW  = 2 * COORD_WIDTH;
  localparam int RXW = (NW + 1 > RADIUS_W + 1) ? NW + 1 : RADIUS_W + 1;
  localparam int RSH = ANG_FRAC - OUT_FRAC;

  logic [RXW-1:0]          rx;
  logic [RADIUS_W-1:0]     radius_nxt;
  zval_t                   zr, ang;

  logic                    v_r;
  logic [RADIUS_W-1:0]     radius_r;
  logic signed [ANG_W-1:0] angle_r;
  loc_t                    loc_r;

  always_comb begin
    // round half up: leftover above the root means nearer the next integer
    rx = RXW'(in_root) + RXW'(in_rem > in_root);
    if (rx > RXW'({RADIUS_W{1'b1}})) begin
      radius_nxt = {RADIUS_W{1'b1}};
    end else begin
      radius_nxt = rx[RADIUS_W-1:0];
    end

    zr = (in_z + (zval_t'(1) <<< (RSH - 1))) >>> RSH;

    unique case (in_loc)
      LOC_ORIGIN: ang = DEG0;
      LOC_POS_X:  ang = DEG0;
      LOC_POS_Y:  ang = DEG90;
      LOC_NEG_X:  ang = DEG180;
      LOC_NEG_Y:  ang = -DEG90;
      LOC_QUAD1:  ang = clamp_ang(zr, DEG0, DEG90);
      LOC_QUAD2:  ang = clamp_ang(zr, DEG90, DEG180);
      LOC_QUAD3:  ang = clamp_ang(zr, -DEG180, -DEG90);
      LOC_QUAD4:  ang = clamp_ang(zr, -DEG90, DEG0);
      default:    ang = DEG0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      radius_r <= radius_nxt;
      angle_r  <= ang[ANG_W-1:0];
      loc_r    <= in_loc;
    end
  end

  assign out_valid  = v_r;
  assign out_radius = radius_r;
  assign out_angle  = angle_r;
  assign out_loc    = loc_r;

endmodule

`default_nettype wire

@@ rtl/cartesian_to_polar_converter_unit.sv @@
`default_nettype none

// Cartesian to polar converter. Each beat on the input carries a signed point
// (x_coord, y_coord); each output beat carries the rounded radius, the angle
// atan2(y, x) in degrees with 7 fraction bits (-180.0 to +180.0) and a class
// code (origin, a half-axis or a quadrant). One point enters per clock cycle
// while the output is not stalled. The datapath is an unrolled stage chain in
// which each stage does one CORDIC vectoring iteration and resolves one bit
// of the square root side by side, while steps of each remain. A stall on the
// output freezes the whole pipeline, so in_tready follows out_tready whenever
// a result is waiting.
module cartesian_to_polar_converter_unit #(
  parameter int COORD_WIDTH  = c2p_pkg::C2P_COORD_WIDTH,
  parameter int CORDIC_STEPS = c2p_pkg::C2P_CORDIC_STEPS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // x_coord, y_coord
  input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0]   in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // radius[15:0], angle_deg[31:16], location[35:32]
  output logic [c2p_pkg::OUT_TDATA_W-1:0]           out_tdata
);
  import c2p_pkg::*;

  localparam int W      = COORD_WIDTH;
  localparam int NW     = 2 * W;
  localparam int XW     = W + 19;
  localparam int NSTEPS = (CORDIC_STEPS > C2P_TABLE_LEN) ? C2P_TABLE_LEN : CORDIC_STEPS;
  localparam int NIT    = (NSTEPS > W) ? NSTEPS : W;

  logic en;

  logic                 v_s    [0:NIT];
  loc_t                 loc_s  [0:NIT];
  logic [NW-1:0]        rem_s  [0:NIT];
  logic [NW-1:0]        root_s [0:NIT];
  logic signed [XW-1:0] cx_s   [0:NIT];
  logic signed [XW-1:0] cy_s   [0:NIT];
  zval_t                z_s    [0:NIT];

  logic                    res_valid;
  logic [RADIUS_W-1:0]     res_radius;
  logic signed [ANG_W-1:0] res_angle;
  loc_t                    res_loc;

  // advance everything unless a finished beat is held at the output
  assign en        = !res_valid || out_tready;
  assign in_tready = en;

  c2p_front #(
    .COORD_WIDTH (W),
    .XW          (XW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .x_coord   (in_tdata[W-1:0]),
    .y_coord   (in_tdata[NW-1:W]),
    .out_valid (v_s[0]),
    .out_loc   (loc_s[0]),
    .out_n     (rem_s[0]),
    .out_cx    (cx_s[0]),
    .out_cy    (cy_s[0]),
    .out_z     (z_s[0])
  );

  assign root_s[0] = '0;

  for (genvar i = 0; i < NIT; i++) begin : g_stage
    c2p_stage #(
      .COORD_WIDTH (W),
      .XW          (XW),
      .NSTEPS      (NSTEPS),
      .IDX         (i)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (v_s[i]),
      .in_loc    (loc_s[i]),
      .in_rem    (rem_s[i]),
      .in_root   (root_s[i]),
      .in_cx     (cx_s[i]),
      .in_cy     (cy_s[i]),
      .in_z      (z_s[i]),
      .out_valid (v_s[i+1]),
      .out_loc   (loc_s[i+1]),
      .out_rem   (rem_s[i+1]),
      .out_root  (root_s[i+1]),
      .out_cx    (cx_s[i+1]),
      .out_cy    (cy_s[i+1]),
      .out_z     (z_s[i+1])
    );
  end

  c2p_back #(
    .COORD_WIDTH (W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (v_s[NIT]),
    .in_loc     (loc_s[NIT]),
    .in_rem     (rem_s[NIT]),
    .in_root    (root_s[NIT]),
    .in_z       (z_s[NIT]),
    .out_valid  (res_valid),
    .out_radius (res_radius),
    .out_angle  (res_angle),
    .out_loc    (res_loc)
  );

  assign out_tvalid = res_valid;
  assign out_tdata  = OUT_TDATA_W'({res_loc, res_angle, res_radius});

endmodule

`default_nettype wire

@@ tb/c2p_result_checker.sv @@
module c2p_result_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  // x_coord[15:0], y_coord[31:16]
  input  wire logic [31:0]                     in_tdata,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  // radius[15:0], angle_deg[31:16], location[35:32]
  input  wire logic [c2p_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                                   mismatch_count,
  output int                                   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import c2p_pkg::*;

  localparam int     VECTOR_STEPS = (C2P_CORDIC_STEPS > 32) ? 32 : C2P_CORDIC_STEPS;
  localparam longint QUARTER_TURN = 11520;
  localparam longint HALF_TURN    = 23040;
  localparam longint QUARTER_FULL = 90 * 65536;
  localparam int     REPORT_LIMIT = 10;

  // atan(2^-i) in degrees, 16 fraction bits
  localparam longint ATAN_STEP_DEG [0:31] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0,
    0, 0, 0, 0, 0, 0, 0, 0
  };

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [15:0]        radius;
    logic signed [15:0] angle;
    loc_t               location;
  } polar_point_t;

  polar_point_t polar_q[$];
  int           fails = 0;

  function automatic longint unsigned round_sqrt(longint unsigned n);
    longint unsigned rem, root, bitv;
    rem  = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (n - root * root > root) root = root + 1;
    return root;
  endfunction

  // Vectoring CORDIC; returns degrees with 7 fraction bits
  function automatic longint vector_angle(longint x, longint y);
    longint z, cx, cy, dx, dy, t;
    z = 0;
    // fold the left half-plane onto the right one
    if (x < 0) begin
      t = x;
      if (y > 0) begin
        x = y;
        y = -t;
        z = QUARTER_FULL;
      end else begin
        x = -y;
        y = t;
        z = -QUARTER_FULL;
      end
    end
    cx = x * 65536;
    cy = y * 65536;
    for (int i = 0; i < VECTOR_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        z  = z + ATAN_STEP_DEG[i];
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        z  = z - ATAN_STEP_DEG[i];
      end
    end
    return (z + 256) >>> 9;
  endfunction

  function automatic longint limit_to(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic polar_point_t convert_point(logic signed [15:0] x, logic signed [15:0] y);
    polar_point_t    p;
    longint          sx, sy, ang;
    longint unsigned mag;
    sx  = x;
    sy  = y;
    mag = round_sqrt(sx * sx + sy * sy);
    if (mag > 65535) mag = 65535;
    p.x      = x;
    p.y      = y;
    p.radius = mag[15:0];
    if (sx == 0 && sy == 0) begin
      p.location = LOC_ORIGIN;
      ang = 0;
    end else if (sy == 0) begin
      if (sx > 0) begin
        p.location = LOC_POS_X;
        ang = 0;
      end else begin
        p.location = LOC_NEG_X;
        ang = HALF_TURN;
      end
    end else if (sx == 0) begin
      if (sy > 0) begin
        p.location = LOC_POS_Y;
        ang = QUARTER_TURN;
      end else begin
        p.location = LOC_NEG_Y;
        ang = -QUARTER_TURN;
      end
    end else begin
      ang = vector_angle(sx, sy);
      // hold the angle inside its quadrant
      if (sx > 0 && sy > 0) begin
        p.location = LOC_QUAD1;
        ang = limit_to(ang, 0, QUARTER_TURN);
      end else if (sx < 0 && sy > 0) begin
        p.location = LOC_QUAD2;
        ang = limit_to(ang, QUARTER_TURN, HALF_TURN);
      end else if (sx < 0) begin
        p.location = LOC_QUAD3;
        ang = limit_to(ang, -HALF_TURN, -QUARTER_TURN);
      end else begin
        p.location = LOC_QUAD4;
        ang = limit_to(ang, -QUARTER_TURN, 0);
      end
    end
    p.angle = ang[15:0];
    return p;
  endfunction

  function automatic void flag_mismatch(string what);
    fails++;
    if (fails <= REPORT_LIMIT) $display("[%0t] %s", $time, what);
  endfunction

  always @(posedge clk) begin : watch
    polar_point_t want;
    logic [15:0]  got_radius;
    logic [15:0]  got_angle;
    logic [3:0]   got_loc;
    if (!rst_n) begin
      polar_q.delete();
    end else begin
      // pop before push so that a beat can never match its own point
      if (out_tvalid && out_tready) begin
        got_radius = out_tdata[15:0];
        got_angle  = out_tdata[31:16];
        got_loc    = out_tdata[35:32];
        if (polar_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result beat: radius %0d angle %0d location %0d",
                                  got_radius, $signed(got_angle), got_loc));
        end else begin
          want = polar_q.pop_front();
          if (got_radius !== want.radius || got_angle !== want.angle ||
              got_loc !== want.location) begin
            flag_mismatch($sformatf(
              "point (%0d,%0d): radius %0d/%0d angle %0d/%0d location %0d/%0d (exp/got)",
              want.x, want.y, want.radius, got_radius, want.angle, $signed(got_angle),
              want.location, got_loc));
          end
        end
      end
      if (in_tvalid && in_tready) polar_q.push_back(convert_point(in_tdata[15:0], in_tdata[31:16]));
    end
    mismatch_count <= fails;
    outstanding    <= polar_q.size();
  end

endmodule

@@ tb/cartesian_to_polar_converter_unit_tb.sv @@
module cartesian_to_polar_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_POINTS   = 1525;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int TAIL_CYCLES     = 40;
  localparam int CORNER_POINTS   = 25;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  // x_coord[15:0], y_coord[31:16]
  logic [31:0]                     in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  // radius[15:0], angle_deg[31:16], location[35:32]
  logic [c2p_pkg::OUT_TDATA_W-1:0] out_tdata;
  int                              mismatch_count;
  int                              outstanding;
  bit                              hold_off_req = 1'b0;

  int corner_x [CORNER_POINTS] = '{
    0, 32767, -32768, 0, 0, -32768, 32767, -32768, 32767, 1, -1, -1, 1,
    1, -1, 0, 0, 32767, 1, -32768, -32768, 1, -1, 100, 3
  };
  int corner_y [CORNER_POINTS] = '{
    0, 0, 0, 32767, -32768, -32768, 32767, 32767, -32768, 1, 1, -1, -1,
    0, 0, 1, -1, 1, 32767, 1, -1, -32768, -32768, -100, 4
  };

  cartesian_to_polar_converter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  c2p_result_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .outstanding    (outstanding)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_point(input logic [15:0] x, input logic [15:0] y, input int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin : stimulus
    int rx, ry, gap, sel;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < CORNER_POINTS; i++) begin
      send_point(corner_x[i][15:0], corner_y[i][15:0], pick_gap());
    end

    for (int i = 0; i < RANDOM_POINTS; i++) begin
      sel = $urandom_range(0, 9);
      case (sel)
        0, 1, 2, 3: begin
          rx = $urandom;
          ry = $urandom;
        end
        4, 5: begin
          // small values land on the origin and the axes often
          rx = int'($urandom_range(0, 16)) - 8;
          ry = int'($urandom_range(0, 16)) - 8;
        end
        6: begin
          rx = $urandom;
          ry = 0;
          if ($urandom_range(0, 1)) begin
            ry = rx;
            rx = 0;
          end
        end
        7: begin
          rx = ($urandom_range(0, 1) ? 32767 : -32768) + int'($urandom_range(0, 6)) - 3;
          ry = ($urandom_range(0, 1) ? 32767 : -32768) + int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 1)) ry = $urandom;
        end
        default: begin
          // just off an axis or close to a diagonal: exercises the quadrant bounds
          rx = $urandom;
          ry = ($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(1, 3));
          if ($urandom_range(0, 1)) ry = ($urandom_range(0, 1) ? rx : -rx)
                                         + int'($urandom_range(0, 4)) - 2;
          if ($urandom_range(0, 1)) begin
            sel = rx;
            rx  = ry;
            ry  = sel;
          end
        end
      endcase
      if (i == 300 || i == 1100) hold_off_req = 1'b1;
      gap = (i >= 700 && i < 900) ? 0 : pick_gap();
      send_point(rx[15:0], ry[15:0], gap);
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : sink
    out_tready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        // hold off long enough for the pipeline to fill and stall the input
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 99) < 60) begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(100, 300)) @(posedge clk);
        else repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        out_tready <= 1'b0;
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

@@ files.f @@
rtl/c2p_pkg.sv
rtl/c2p_front.sv
rtl/c2p_stage.sv
rtl/c2p_back.sv
rtl/cartesian_to_polar_converter_unit.sv
tb/c2p_result_checker.sv
tb/cartesian_to_polar_converter_unit_tb.sv
